>>> hdl/wgd_tx_pkg.sv
package wgd_tx_pkg;

    // Item kinds carried in the slave-side tuser field.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_START26  = 2'd1;
    localparam logic [1:0] OP_START34  = 2'd2;

    // Frame lengths and the width of the left-aligned frame shifter.
    localparam int FRAME26_BITS = 26;
    localparam int FRAME34_BITS = 34;
    localparam int SHIFT_BITS   = FRAME34_BITS;
    localparam int COUNT_BITS   = 6;

    // Configuration register indexes.
    localparam logic REG_PULSE_TICKS = 1'b0;
    localparam logic REG_GAP_TICKS   = 1'b1;

    // Register reset values and widths.
    localparam int          LEN_BITS        = 16;
    localparam logic [15:0] PULSE_TICKS_RST = 16'd50;
    localparam logic [15:0] GAP_TICKS_RST   = 16'd2000;

    // Field widths of an item.
    localparam int OP_BITS       = 2;
    localparam int FACILITY_BITS = 8;
    localparam int CARD_BITS     = 16;
    localparam int WORD34_BITS   = 32;
    localparam int IN_DATA_BITS  = FACILITY_BITS + CARD_BITS + WORD34_BITS;
    localparam int OUT_DATA_BITS = 8;

    // Line levels and status of one result item.
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic line_one;
        logic line_zero;
    } wgd_result_t;

endpackage

>>> hdl/wiegand_frame_transmitter.sv
// Wiegand 26/34-bit frame transmitter. Every slave-side item is either a one
// microsecond tick (tuser = 0), a 26-bit frame start (tuser = 1, facility and
// card in tdata) or a 34-bit frame start (tuser = 2, word34 in tdata); kind 3
// is a no-op. Every item yields exactly one result item that reports the D0
// and D1 levels, the busy flag and a reject flag. A tick reports the levels of
// the microsecond it stands for and then advances the bit timer; a start
// reports the levels of the first pulse. A start that arrives while a frame
// is still in flight is dropped and flagged as rejected. Both lines idle
// high. Each frame bit pulls D0 (for a zero) or D1 (for a one) low for
// pulse_ticks ticks and is followed by gap_ticks high ticks; a length of zero
// counts as one tick, and new register values apply at the next pulse or gap
// that begins. The block takes one item per clock cycle unless the output
// stalls: the new state and the result are computed in one pass and land in
// the state registers and the single output register at the same edge. An
// item is taken whenever the output register is empty or is being drained in
// the same cycle. Register map (APB, 32-bit data): 0x0 pulse_ticks, 0x4
// gap_ticks, both 16 bits wide; only paddr[2] selects the register.
module wiegand_frame_transmitter
    import wgd_tx_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Slave-side items.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // tdata from bit 0: facility[7:0], card[15:0], word34[31:0]
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // tuser from bit 0: op[1:0]
    input  logic [OP_BITS-1:0]       s_tuser,

    // Master-side result items.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // tdata from bit 0: line_zero, line_one, busy_res, rejected, four zero bits
    output logic [OUT_DATA_BITS-1:0] m_tdata,

    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // Configuration registers.
    logic [LEN_BITS-1:0] pulse_ticks_reg;
    logic [LEN_BITS-1:0] gap_ticks_reg;

    // Frame state. The frame is kept left-aligned so that the bit on the
    // wire is always the top bit of the shifter.
    logic [SHIFT_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [COUNT_BITS-1:0] bits_remaining_reg, bits_remaining_next;
    logic                  in_pulse_reg, in_pulse_next;
    logic [TIMER_BITS-1:0] phase_timer_reg, phase_timer_next;

    // Output register.
    logic                     m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;

    logic                     accept;
    logic                     busy;
    logic [TIMER_BITS-1:0]    pulse_len;
    logic [TIMER_BITS-1:0]    gap_len;
    logic [TIMER_BITS-1:0]    timer_dec;
    logic [COUNT_BITS-1:0]    bits_dec;
    logic [FACILITY_BITS-1:0] facility;
    logic [CARD_BITS-1:0]     card;
    logic [WORD34_BITS-1:0]   word34;
    logic [FACILITY_BITS+CARD_BITS-1:0] payload26;
    logic                     parity_even;
    logic                     parity_odd;
    wgd_result_t              result;
    logic                     cfg_write;

    assign facility  = s_tdata[FACILITY_BITS-1:0];
    assign card      = s_tdata[FACILITY_BITS+CARD_BITS-1:FACILITY_BITS];
    assign word34    = s_tdata[IN_DATA_BITS-1:FACILITY_BITS+CARD_BITS];
    assign payload26 = {facility, card};

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign busy     = (bits_remaining_reg != '0);

    // Lengths are masked to the timer width and a zero length counts as one.
    always_comb
    begin
        pulse_len = TIMER_BITS'(pulse_ticks_reg);
        gap_len   = TIMER_BITS'(gap_ticks_reg);
        if (pulse_len == '0)
        begin
            pulse_len = TIMER_BITS'(1);
        end
        if (gap_len == '0)
        begin
            gap_len = TIMER_BITS'(1);
        end
    end

    assign timer_dec = phase_timer_reg - TIMER_BITS'(1);
    assign bits_dec  = bits_remaining_reg - COUNT_BITS'(1);

    // Parity bits of the frame that a start would load.
    always_comb
    begin
        if (s_tuser == OP_START26)
        begin
            parity_even = ^payload26[23:12];
            parity_odd  = ~^payload26[11:0];
        end
        else
        begin
            parity_even = ^word34[31:16];
            parity_odd  = ~^word34[15:0];
        end
    end

    // Next state and result of the item at the input.
    always_comb
    begin
        frame_shift_next    = frame_shift_reg;
        bits_remaining_next = bits_remaining_reg;
        in_pulse_next       = in_pulse_reg;
        phase_timer_next    = phase_timer_reg;

        // By default report the levels of the current state.
        result.rejected  = 1'b0;
        result.busy_res  = busy;
        result.line_zero = !(busy && in_pulse_reg && !frame_shift_reg[SHIFT_BITS-1]);
        result.line_one  = !(busy && in_pulse_reg && frame_shift_reg[SHIFT_BITS-1]);

        case (s_tuser)
            OP_START26, OP_START34:
            begin
                if (busy)
                begin
                    result.rejected = 1'b1;
                end
                else
                begin
                    if (s_tuser == OP_START26)
                    begin
                        frame_shift_next = {parity_even, payload26, parity_odd,
                                            (SHIFT_BITS-FRAME26_BITS)'(0)};
                        bits_remaining_next = COUNT_BITS'(FRAME26_BITS);
                    end
                    else
                    begin
                        frame_shift_next    = {parity_even, word34, parity_odd};
                        bits_remaining_next = COUNT_BITS'(FRAME34_BITS);
                    end
                    in_pulse_next    = 1'b1;
                    phase_timer_next = pulse_len;
                    // The first pulse carries the even parity bit.
                    result.busy_res  = 1'b1;
                    result.line_zero = parity_even;
                    result.line_one  = !parity_even;
                end
            end
            OP_TICK:
            begin
                if (busy)
                begin
                    phase_timer_next = timer_dec;
                    if (timer_dec == '0)
                    begin
                        if (in_pulse_reg)
                        begin
                            in_pulse_next    = 1'b0;
                            phase_timer_next = gap_len;
                        end
                        else
                        begin
                            bits_remaining_next = bits_dec;
                            if (bits_dec != '0)
                            begin
                                in_pulse_next    = 1'b1;
                                phase_timer_next = pulse_len;
                                frame_shift_next = {frame_shift_reg[SHIFT_BITS-2:0], 1'b0};
                            end
                            else
                            begin
                                frame_shift_next = '0;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Frame state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg    <= '0;
            bits_remaining_reg <= '0;
            in_pulse_reg       <= 1'b0;
            phase_timer_reg    <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                frame_shift_reg    <= frame_shift_next;
                bits_remaining_reg <= bits_remaining_next;
                in_pulse_reg       <= in_pulse_next;
                phase_timer_reg    <= phase_timer_next;
                m_tvalid_reg       <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {(OUT_DATA_BITS-4)'(0), result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration registers: the access phase of a write updates them.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg <= PULSE_TICKS_RST;
            gap_ticks_reg   <= GAP_TICKS_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_PULSE_TICKS)
            begin
                pulse_ticks_reg <= pwdata[LEN_BITS-1:0];
            end
            else
            begin
                gap_ticks_reg <= pwdata[LEN_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_GAP_TICKS)
        begin
            prdata = {(32-LEN_BITS)'(0), gap_ticks_reg};
        end
        else
        begin
            prdata = {(32-LEN_BITS)'(0), pulse_ticks_reg};
        end
    end

endmodule

>>> verif/wiegand_frame_transmitter_tb.sv
`timescale 1ns / 1ps

module wiegand_frame_transmitter_tb;

    import wgd_tx_pkg::*;

    // Timer width of the instance; it matches the block's default.
    localparam int TMR_BITS = 16;

    // The fourth item kind is not used by the block and acts as a no-op.
    localparam logic [1:0] OP_NOP = 2'd3;

    // One slave-side item before packing.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  facility;
        logic [15:0] card;
        logic [31:0] word34;
    } tx_item_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [OP_BITS-1:0]       s_tuser = '0;

    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    wiegand_frame_transmitter #(
        .TIMER_BITS(TMR_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Items waiting to be sent, and the line levels expected back, oldest first.
    tx_item_t    pending_items[$];
    wgd_result_t expected_levels[$];

    int err_count = 0;
    int result_count = 0;

    // Our own copy of the transmitter: registers and frame state.
    logic [15:0]         cfg_pulse = PULSE_TICKS_RST;
    logic [15:0]         cfg_gap   = GAP_TICKS_RST;
    logic [SHIFT_BITS-1:0] frame_bits = '0;
    logic [COUNT_BITS-1:0] bits_left  = '0;
    logic                  pulse_on   = 1'b0;
    logic [TMR_BITS-1:0]   phase_tmr  = '0;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // A length register of zero still gives a phase of one tick.
    function automatic logic [TMR_BITS-1:0] phase_len(input logic [15:0] reg_val);
        logic [TMR_BITS-1:0] v;
        v = TMR_BITS'(reg_val);
        return (v == '0) ? TMR_BITS'(1) : v;
    endfunction

    // Levels of D0 and D1 and the status flags as the frame state stands now.
    function automatic wgd_result_t line_state(input logic rej);
        wgd_result_t r;
        logic        busy;
        logic        low;
        logic        bit_now;
        busy = (bits_left != '0);
        low  = busy && pulse_on;
        bit_now = 1'b0;
        if (busy && bits_left <= COUNT_BITS'(FRAME34_BITS))
            bit_now = frame_bits[bits_left - 1'b1];
        r.line_zero = !(low && !bit_now);
        r.line_one  = !(low && bit_now);
        r.busy_res  = busy;
        r.rejected  = rej;
        return r;
    endfunction

    // Works out the result of one accepted item and moves the frame state on.
    // A start reports the first pulse; a tick reports the microsecond it
    // stands for and then counts the phase timer down.
    task automatic frame_step(input tx_item_t it, output wgd_result_t res);
        logic [23:0] payload;
        logic        was_busy;
        was_busy = (bits_left != '0);
        if ((it.op == OP_START26 || it.op == OP_START34) && was_busy)
        begin
            // A start while a frame is in flight is dropped.
            res = line_state(1'b1);
        end
        else
        begin
            if (it.op == OP_START26)
            begin
                payload    = {it.facility, it.card};
                frame_bits = {8'd0, ^payload[23:12], payload, ~^payload[11:0]};
                bits_left  = COUNT_BITS'(FRAME26_BITS);
            end
            else if (it.op == OP_START34)
            begin
                frame_bits = {^it.word34[31:16], it.word34, ~^it.word34[15:0]};
                bits_left  = COUNT_BITS'(FRAME34_BITS);
            end
            if (it.op == OP_START26 || it.op == OP_START34)
            begin
                pulse_on  = 1'b1;
                phase_tmr = phase_len(cfg_pulse);
            end
            res = line_state(1'b0);
            if (it.op == OP_TICK && was_busy)
            begin
                phase_tmr = phase_tmr - 1'b1;
                if (phase_tmr == '0)
                begin
                    if (pulse_on)
                    begin
                        pulse_on  = 1'b0;
                        phase_tmr = phase_len(cfg_gap);
                    end
                    else
                    begin
                        bits_left = bits_left - 1'b1;
                        if (bits_left != '0)
                        begin
                            pulse_on  = 1'b1;
                            phase_tmr = phase_len(cfg_pulse);
                        end
                        else
                        begin
                            frame_bits = '0;
                        end
                    end
                end
            end
        end
    endtask

    // Sender. Items go out in bursts of random length; between bursts the
    // valid line drops for a few cycles, and now and then a long burst runs
    // with no gaps at all. The expectation for an item is computed at the
    // edge where it is accepted.
    tx_item_t    cur_item;
    wgd_result_t cur_levels;
    int          burst_left;
    int          gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left = 10;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                frame_step(cur_item, cur_levels);
                expected_levels.push_back(cur_levels);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    cur_item = pending_items.pop_front();
                    s_tuser  <= cur_item.op;
                    s_tdata  <= {cur_item.word34, cur_item.card, cur_item.facility};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 9) < 3)
                        begin
                            burst_left = $urandom_range(50, 300);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = $urandom_range(1, 6);
                        end
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker. Ready follows a rotating 16-bit pattern that is
    // replaced when pat_age wraps; an all-ones pattern gives a stretch with no
    // stalls. Each accepted result is compared with the oldest expectation.
    logic [15:0] ready_pat;
    logic [7:0]  pat_age;
    wgd_result_t want;
    wgd_result_t got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            ready_pat = 16'hFFFF;
            pat_age   = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_levels.size() == 0)
                begin
                    flag_error($sformatf("result %0d arrived with nothing expected",
                                         result_count));
                end
                else
                begin
                    want = expected_levels.pop_front();
                    got  = wgd_result_t'(m_tdata[3:0]);
                    if (got.line_zero !== want.line_zero)
                        flag_error($sformatf("result %0d: line_zero %b, expected %b",
                                             result_count, got.line_zero, want.line_zero));
                    if (got.line_one !== want.line_one)
                        flag_error($sformatf("result %0d: line_one %b, expected %b",
                                             result_count, got.line_one, want.line_one));
                    if (got.busy_res !== want.busy_res)
                        flag_error($sformatf("result %0d: busy_res %b, expected %b",
                                             result_count, got.busy_res, want.busy_res));
                    if (got.rejected !== want.rejected)
                        flag_error($sformatf("result %0d: rejected %b, expected %b",
                                             result_count, got.rejected, want.rejected));
                    if (m_tdata[7:4] !== 4'b0000)
                        flag_error($sformatf("result %0d: pad bits %b, expected zero",
                                             result_count, m_tdata[7:4]));
                end
                result_count++;
            end
            m_tready  <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            pat_age++;
            if (pat_age == '0)
            begin
                if ($urandom_range(0, 3) == 0)
                    ready_pat = 16'hFFFF;
                else
                    ready_pat = 16'($urandom) | 16'h0101;
            end
        end
    end

    // Queues an item; the callers choose the values of the fields a given kind does not use.
    task automatic queue_item(input logic [1:0] op, input logic [7:0] fac,
                              input logic [15:0] card, input logic [31:0] word);
        tx_item_t it;
        it.op       = op;
        it.facility = fac;
        it.card     = card;
        it.word34   = word;
        pending_items.push_back(it);
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            queue_item(OP_TICK, 8'($urandom), 16'($urandom), $urandom);
    endtask

    // Mostly ticks, so frames run to their end, with starts (many of them
    // landing while busy) and a few no-ops mixed in.
    task automatic queue_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82)
            queue_item(OP_TICK, 8'($urandom), 16'($urandom), $urandom);
        else if (r < 89)
            queue_item(OP_START26, 8'($urandom), 16'($urandom), $urandom);
        else if (r < 96)
            queue_item(OP_START34, 8'($urandom), 16'($urandom), $urandom);
        else
            queue_item(OP_NOP, 8'($urandom), 16'($urandom), $urandom);
    endtask

    // Waits until every queued item is accepted and every result has arrived.
    // The state is looked at on the falling edge, away from the driving edge.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_levels.size() != 0)
            @(negedge clk);
    endtask

    // Ticks the frame in flight, if any, through to its last gap.
    task automatic finish_frame();
        wait_drained();
        while (bits_left != '0)
        begin
            queue_ticks(64);
            wait_drained();
        end
    endtask

    // Register write: a setup cycle, then an access cycle whose closing edge
    // writes the register. The upper data bits are random and not stored.
    task automatic reg_write(input logic idx, input logic [15:0] val);
        logic [31:0] wd;
        wd       = $urandom;
        wd[15:0] = val;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PULSE_TICKS)
            cfg_pulse = val;
        else
            cfg_gap = val;
    endtask

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'd1;
            default: return 16'($urandom_range(2, 4));
        endcase
    endfunction

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset lengths, the first pulse must last 50 ticks. Shorter
        // lengths written partway through that pulse only take hold at the
        // gap that follows it.
        queue_item(OP_START26, 8'hA5, 16'h3C0F, $urandom);
        queue_ticks(30);
        wait_drained();
        reg_write(REG_PULSE_TICKS, 16'd1);
        reg_write(REG_GAP_TICKS, 16'd2);
        finish_frame();

        // Directed items: idle ticks and no-ops, starts while busy, a no-op
        // in the middle of a frame, and field extremes of both formats.
        queue_item(OP_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(OP_NOP, 8'h00, 16'h0000, 32'h0000_0000);
        queue_item(OP_START26, 8'hFF, 16'h0000, 32'h0000_0000);
        queue_item(OP_TICK, 8'h00, 16'h0000, 32'h0000_0000);
        queue_item(OP_NOP, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(OP_START34, 8'h00, 16'h0000, 32'h1234_5678);
        queue_item(OP_START26, 8'h12, 16'h3456, 32'h0);
        queue_item(OP_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        finish_frame();
        queue_item(OP_START34, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        finish_frame();
        queue_item(OP_START34, 8'hFF, 16'hFFFF, 32'h0000_0000);
        finish_frame();
        queue_item(OP_START26, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
        finish_frame();
        queue_item(OP_START26, 8'hFF, 16'hFFFF, 32'h0);
        finish_frame();

        // Zero lengths behave as one tick each.
        reg_write(REG_PULSE_TICKS, 16'd0);
        reg_write(REG_GAP_TICKS, 16'd0);
        queue_item(OP_START34, 8'($urandom), 16'($urandom), $urandom);
        finish_frame();

        // Random phases with short lengths. The registers are rewritten with
        // the frame often still in flight, so new values meet every phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            if ($urandom_range(0, 1) == 0)
            begin
                reg_write(REG_PULSE_TICKS, pick_len());
                reg_write(REG_GAP_TICKS, pick_len());
            end
            else
            begin
                reg_write(REG_GAP_TICKS, pick_len());
                reg_write(REG_PULSE_TICKS, pick_len());
            end
            for (int i = 0; i < 80; i++)
                queue_random_item();
        end
        finish_frame();

        // Let the output register settle before the final verdict.
        repeat (10) @(posedge clk);
        if (expected_levels.size() != 0)
            flag_error($sformatf("%0d expected results never arrived",
                                 expected_levels.size()));
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog well beyond the slowest run the stimulus can take.
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
hdl/wgd_tx_pkg.sv
hdl/wiegand_frame_transmitter.sv
verif/wiegand_frame_transmitter_tb.sv
